[rtl/core/pwg_pkg.sv]
// Package: shared constants, types and quarter-wave table builder for the level generator.
package pwg_pkg;

  localparam int unsigned PHASE_W    = 11;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned SHAPE_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Quarter period spans 512 phase steps; table holds both end points.
  localparam int unsigned QUARTER    = 512;
  localparam int unsigned QTAB_DEPTH = QUARTER + 1;
  localparam int unsigned QADDR_W    = 10;
  localparam int unsigned QDATA_W    = 16;

  localparam int unsigned ONE_Q15    = 32768;
  localparam int unsigned WAVE_W     = 17;

  // Sawtooth: rising edge covers phase 0..SAW_KNEE, falling edge the rest.
  localparam int unsigned SAW_KNEE   = 1945;
  localparam int unsigned SAW_SLOPE  = 320;
  localparam int unsigned SAW_BIAS   = 9;
  // floor(m / 19) = (m * SAW_RECIP) >> SAW_SHIFT, exact for m < 2^20
  localparam int unsigned SAW_RECIP  = 1766023;
  localparam int unsigned SAW_SHIFT  = 25;

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SINE     = 3'd0,
    SHAPE_SQUARE   = 3'd1,
    SHAPE_TRIANGLE = 3'd2,
    SHAPE_COSINE   = 3'd3,
    SHAPE_SAWTOOTH = 3'd4
  } shape_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_SHAPE = 2'd0,
    CFG_MIN_LEVEL  = 2'd1,
    CFG_MAX_LEVEL  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SHAPE_W-1:0] wave_shape;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
  } cfg_t;

  // Wave stage result: either a direct value or a signed table lookup.
  typedef struct packed {
    logic                     use_rom;
    logic                     neg;
    logic signed [WAVE_W-1:0] wave;
  } wave_t;

  typedef logic [QTAB_DEPTH-1:0][QDATA_W-1:0] qtab_t;

  // Quarter-wave sine in Q1.15, Taylor series in Q30, evaluated at elaboration.
  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] r;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] out_v;
    tab = '0;
    for (int k = 0; k < QTAB_DEPTH; k++) begin
      r     = 64'(k) << 21;
      theta = (r * 64'd1686629713) >> 30;
      x2    = (theta * theta) >> 30;
      term  = theta;
      sum   = theta;
      term  = ((term * x2) >> 30) / 64'd6;
      sum   = sum - term;
      term  = ((term * x2) >> 30) / 64'd20;
      sum   = sum + term;
      term  = ((term * x2) >> 30) / 64'd42;
      sum   = sum - term;
      term  = ((term * x2) >> 30) / 64'd72;
      sum   = sum + term;
      term  = ((term * x2) >> 30) / 64'd110;
      sum   = sum - term;
      out_v = (sum + 64'd16384) >> 15;
      if (out_v > 64'(ONE_Q15)) begin
        out_v = 64'(ONE_Q15);
      end
      tab[k] = out_v[QDATA_W-1:0];
    end
    return tab;
  endfunction

endpackage

[rtl/core/pwg_intf.sv]
// Interfaces: phase input stream, level output stream and register write channel.
interface pwg_phase_if;
  logic                            valid;
  logic                            ready;
  logic [pwg_pkg::PHASE_W-1:0]     phase_index;
  modport source (output valid, output phase_index, input ready);
  modport sink   (input valid, input phase_index, output ready);
endinterface

interface pwg_level_if;
  logic                            valid;
  logic                            ready;
  logic [pwg_pkg::LEVEL_W-1:0]     level;
  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface pwg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pwg_pkg::CFG_IDX_W-1:0]   index;
  logic [pwg_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/periodic_waveform_level_generator.sv]
// Top level: three-stage level generator, phase in, clamped Q1.15 level out.
// Throughput: one beat per cycle while the level output is not stalled; the
// stages are input register, wave/ROM register and scaled-level register,
// the ROM read setting the middle one. A phase beat is registered in each
// stage in that order before its level beat is offered.
// Reset: clears the stage valid bits and loads shape sine, min 0, max 1.0.
// Register writes are taken in any cycle (ready held high).
module periodic_waveform_level_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  pwg_phase_if.sink   in_phase,
  pwg_level_if.source out_level,
  pwg_cfg_if.sink     cfg
);

  pwg_pkg::cfg_t                cfg_w;
  logic [pwg_pkg::PHASE_W-1:0]  phase_q;
  pwg_pkg::wave_t               wave;
  logic [pwg_pkg::QDATA_W-1:0]  rom_data;
  logic [pwg_pkg::LEVEL_W-1:0]  level;

  // One valid bit per stage; a stage advances when the next one is free
  // or moving on, so a stalled output does not hold up empty stages.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || out_level.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_phase.ready = en1;
  assign cfg.ready      = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_phase.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Input register; the period is exactly the index range so no wrap needed.
  always_ff @(posedge clk_i) begin
    if (en1 && in_phase.valid) begin
      phase_q <= in_phase.phase_index;
    end
  end

  pwg_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg.valid),
    .wr_index_i (cfg.index),
    .wr_data_i  (cfg.data),
    .cfg_o      (cfg_w)
  );

  // Stage two: shape evaluation and quarter-wave lookup.
  pwg_wave_gen u_wave_gen (
    .clk_i      (clk_i),
    .en_i       (en2),
    .phase_i    (phase_q),
    .shape_i    (cfg_w.wave_shape),
    .wave_o     (wave),
    .rom_data_o (rom_data)
  );

  // Stage three: one 18x17 multiply, add of the floor bound, clamp.
  pwg_level_map u_level_map (
    .clk_i      (clk_i),
    .en_i       (en3),
    .wave_i     (wave),
    .rom_data_i (rom_data),
    .cfg_i      (cfg_w),
    .level_o    (level)
  );

  assign out_level.valid = v3_q;
  assign out_level.level = level;

endmodule

[rtl/core/pwg_cfg_regs.sv]
// Configuration registers: wave shape and the two level bounds.
module pwg_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [pwg_pkg::CFG_IDX_W-1:0]   wr_index_i,
  input  logic [pwg_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output pwg_pkg::cfg_t                   cfg_o
);

  pwg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_shape <= pwg_pkg::SHAPE_SINE;
      cfg_q.min_level  <= '0;
      cfg_q.max_level  <= pwg_pkg::LEVEL_W'(pwg_pkg::ONE_Q15);
    end else if (wr_en_i) begin
      case (wr_index_i)
        pwg_pkg::CFG_WAVE_SHAPE: cfg_q.wave_shape <= wr_data_i[pwg_pkg::SHAPE_W-1:0];
        pwg_pkg::CFG_MIN_LEVEL:  cfg_q.min_level  <= wr_data_i[pwg_pkg::LEVEL_W-1:0];
        pwg_pkg::CFG_MAX_LEVEL:  cfg_q.max_level  <= wr_data_i[pwg_pkg::LEVEL_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/pwg_qrom.sv]
// Quarter-wave sine ROM with registered read.
module pwg_qrom (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [pwg_pkg::QADDR_W-1:0]   addr_i,
  output logic [pwg_pkg::QDATA_W-1:0]   data_o
);

  localparam pwg_pkg::qtab_t QTAB = pwg_pkg::build_qtab();

  logic [pwg_pkg::QDATA_W-1:0] data_q;
  logic [pwg_pkg::QADDR_W-1:0] addr_c;

  // addresses above the last entry never occur; clip anyway
  assign addr_c = (addr_i > pwg_pkg::QADDR_W'(pwg_pkg::QUARTER))
                  ? pwg_pkg::QADDR_W'(pwg_pkg::QUARTER) : addr_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= QTAB[addr_c];
    end
  end

  assign data_o = data_q;

endmodule

[rtl/core/pwg_wave_gen.sv]
// Wave stage: evaluates the selected shape at a phase; sine/cosine via the ROM.
module pwg_wave_gen (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [pwg_pkg::PHASE_W-1:0]   phase_i,
  input  logic [pwg_pkg::SHAPE_W-1:0]   shape_i,
  output pwg_pkg::wave_t                wave_o,
  output logic [pwg_pkg::QDATA_W-1:0]   rom_data_o
);

  localparam int unsigned SAW_M_W = 20;
  localparam int unsigned SAW_R_W = 21;

  logic [pwg_pkg::PHASE_W-1:0]       pc;
  logic [1:0]                        quad;
  logic [8:0]                        k;
  logic [pwg_pkg::QADDR_W-1:0]       rom_addr;
  logic                              tri_quad_odd;
  logic signed [pwg_pkg::WAVE_W-1:0] tri_t;
  logic signed [pwg_pkg::WAVE_W-1:0] tri_w;
  logic signed [pwg_pkg::WAVE_W-1:0] sq_w;
  logic [SAW_M_W-1:0]                saw_m;
  logic [SAW_M_W+SAW_R_W-1:0]        saw_prod;
  logic [15:0]                       saw_g;
  logic [11:0]                       saw_fall;
  logic signed [pwg_pkg::WAVE_W-1:0] saw_w;
  pwg_pkg::wave_t                    wave_d;
  pwg_pkg::wave_t                    wave_q;

  // cosine is the sine a quarter period later
  assign pc   = (shape_i == pwg_pkg::SHAPE_COSINE)
                ? phase_i + pwg_pkg::PHASE_W'(pwg_pkg::QUARTER) : phase_i;
  assign quad = pc[10:9];
  assign k    = pc[8:0];
  assign rom_addr = quad[0] ? (pwg_pkg::QADDR_W'(pwg_pkg::QUARTER) - {1'b0, k})
                            : {1'b0, k};

  // triangle, from the raw phase
  assign tri_quad_odd = phase_i[9];
  assign tri_t = $signed({2'b00, phase_i[8:0], 6'b0});
  always_comb begin
    tri_w = tri_quad_odd ? (pwg_pkg::WAVE_W'(pwg_pkg::ONE_Q15) - tri_t) : tri_t;
    if (phase_i[10]) begin
      tri_w = -tri_w;
    end
  end

  // square: high strictly inside the first half
  assign sq_w = ((phase_i != '0) && !phase_i[10])
                ? pwg_pkg::WAVE_W'(pwg_pkg::ONE_Q15)
                : -pwg_pkg::WAVE_W'(pwg_pkg::ONE_Q15);

  // sawtooth: rising edge is floor((320p + 9) / 19) by reciprocal multiply
  assign saw_m    = SAW_M_W'(pwg_pkg::SAW_SLOPE) * SAW_M_W'(phase_i)
                    + SAW_M_W'(pwg_pkg::SAW_BIAS);
  assign saw_prod = (SAW_M_W+SAW_R_W)'(saw_m) * (SAW_M_W+SAW_R_W)'(pwg_pkg::SAW_RECIP);
  assign saw_fall = 12'd2048 - {1'b0, phase_i};
  always_comb begin
    if (phase_i <= pwg_pkg::PHASE_W'(pwg_pkg::SAW_KNEE)) begin
      saw_g = saw_prod[pwg_pkg::SAW_SHIFT +: 16];
    end else begin
      saw_g = 16'(16'(pwg_pkg::SAW_SLOPE) * {4'b0, saw_fall});
    end
    saw_w = $signed({saw_g, 1'b0}) - pwg_pkg::WAVE_W'(pwg_pkg::ONE_Q15);
  end

  always_comb begin
    wave_d.use_rom = 1'b0;
    wave_d.neg     = quad[1];
    wave_d.wave    = '0;
    case (shape_i)
      pwg_pkg::SHAPE_SQUARE:   wave_d.wave = sq_w;
      pwg_pkg::SHAPE_TRIANGLE: wave_d.wave = tri_w;
      pwg_pkg::SHAPE_SAWTOOTH: wave_d.wave = saw_w;
      default:                 wave_d.use_rom = 1'b1; // sine, cosine, unused codes
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wave_q <= wave_d;
    end
  end

  pwg_qrom u_qrom (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .addr_i (rom_addr),
    .data_o (rom_data_o)
  );

  assign wave_o = wave_q;

endmodule

[rtl/core/pwg_level_map.sv]
// Level stage: scales the wave between the bounds and clamps to 0..1.0.
module pwg_level_map (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  pwg_pkg::wave_t                wave_i,
  input  logic [pwg_pkg::QDATA_W-1:0]   rom_data_i,
  input  pwg_pkg::cfg_t                 cfg_i,
  output logic [pwg_pkg::LEVEL_W-1:0]   level_o
);

  logic signed [pwg_pkg::WAVE_W-1:0] rom_s;
  logic signed [pwg_pkg::WAVE_W-1:0] w;
  logic signed [17:0]                u;
  logic signed [16:0]                d;
  logic signed [34:0]                prod;
  logic signed [18:0]                scaled;
  logic signed [19:0]                lvl;
  logic [pwg_pkg::LEVEL_W-1:0]       level_d;
  logic [pwg_pkg::LEVEL_W-1:0]       level_q;

  assign rom_s  = $signed({1'b0, rom_data_i});
  assign w      = wave_i.use_rom ? (wave_i.neg ? -rom_s : rom_s) : wave_i.wave;
  assign u      = 18'(w) + 18'(pwg_pkg::ONE_Q15);
  assign d      = $signed({1'b0, cfg_i.max_level}) - $signed({1'b0, cfg_i.min_level});
  assign prod   = 35'(u) * 35'(d);
  assign scaled = 19'((prod + 35'sd32768) >>> 16);
  assign lvl    = 20'(scaled) + $signed({4'b0, cfg_i.min_level});

  always_comb begin
    if (lvl < 0) begin
      level_d = '0;
    end else if (lvl > 20'sd32768) begin
      level_d = pwg_pkg::LEVEL_W'(pwg_pkg::ONE_Q15);
    end else begin
      level_d = lvl[pwg_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

[test/periodic_waveform_level_generator_tb.sv]
// Testbench: streams phase beats through the level generator and checks every level beat.
module periodic_waveform_level_generator_tb;
  import pwg_pkg::*;

  // Stream geometry and fixed-point constants of the level predictor.
  localparam longint unsigned PERIOD_STEPS = 64'd2048;
  localparam longint unsigned QUARTER_TURN = 64'd1 << 30;
  localparam longint unsigned HALF_TURN    = 64'd1 << 31;
  localparam longint unsigned FULL_TURN    = 64'd1 << 32;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint          UNIT_LEVEL   = 64'sd32768;

  // Shape code with no shape of its own, and the register index past the list.
  localparam logic [SHAPE_W-1:0]   SHAPE_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX   = 2'd3;

  // Cycles with no beat on any channel before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;

  typedef struct {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
  } level_beat_t;

  logic clk_i;
  logic rst_ni;

  pwg_phase_if phase_bus ();
  pwg_level_if level_bus ();
  pwg_cfg_if   cfg_bus ();

  periodic_waveform_level_generator dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_phase  (phase_bus),
    .out_level (level_bus),
    .cfg       (cfg_bus)
  );

  // Shadow of the register file, as the block holds it after reset.
  logic [SHAPE_W-1:0] cur_shape = SHAPE_SINE;
  logic [LEVEL_W-1:0] cur_min   = '0;
  logic [LEVEL_W-1:0] cur_max   = LEVEL_W'(ONE_Q15);

  // Levels still owed by the block, oldest first.
  level_beat_t pending_levels[$];

  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned level_errors    = 0;
  int unsigned phase_beats     = 0;
  int unsigned level_beats     = 0;
  int unsigned settings_count  = 0;
  int unsigned quiet_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Level predictor
  // ---------------------------------------------------------------------------

  // Signed Q1.15 sine of a 32-bit period fraction. The quarter-wave magnitude is
  // an odd Taylor series in Q30 up to the x^11 term, rounded to Q1.15 and capped
  // at 1.0; odd quadrants run the quarter backwards, the second half is negated.
  function automatic longint sine_q15(input longint unsigned frac);
    longint unsigned quad;
    longint unsigned r;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned mag;
    quad = (frac >> 30) & 64'd3;
    r    = frac & (QUARTER_TURN - 1);
    if ((quad & 64'd1) != 0) begin
      r = QUARTER_TURN - r;
    end
    theta = (r * HALF_PI_Q30) >> 30;
    x2    = (theta * theta) >> 30;
    term  = theta;
    sum   = theta;
    for (int n = 1; n <= 5; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    mag = (sum + 64'd16384) >> 15;
    if (mag > 64'(ONE_Q15)) begin
      mag = 64'(ONE_Q15);
    end
    return (quad >= 2) ? -longint'(mag) : longint'(mag);
  endfunction

  // Level the block owes for one phase beat under the current register shadow.
  function automatic logic [LEVEL_W-1:0] wave_level(input logic [PHASE_W-1:0] phase);
    longint unsigned frac;
    longint unsigned quad;
    longint unsigned g;
    longint          t;
    longint          w;
    longint          u;
    longint          d;
    longint          lvl;
    frac = (64'(phase) % PERIOD_STEPS << 32) / PERIOD_STEPS;
    quad = (frac >> 30) & 64'd3;
    case (cur_shape)
      SHAPE_SQUARE: begin
        // High only where the sine is strictly positive: phase 0 and one half are low.
        w = (frac > 0 && frac < HALF_TURN) ? UNIT_LEVEL : -UNIT_LEVEL;
      end
      SHAPE_TRIANGLE: begin
        t = longint'(((frac & (QUARTER_TURN - 1)) + 64'd16384) >> 15);
        case (quad)
          64'd0:   w = t;
          64'd1:   w = UNIT_LEVEL - t;
          64'd2:   w = -t;
          default: w = -(UNIT_LEVEL - t);
        endcase
      end
      SHAPE_COSINE: begin
        w = sine_q15((frac + QUARTER_TURN) & (FULL_TURN - 1));
      end
      SHAPE_SAWTOOTH: begin
        // Rises over 19/20 of the period, falls over the last 1/20.
        if (20 * frac < 19 * FULL_TURN) begin
          g = (20 * frac + 19 * (64'd1 << 16)) / (19 * (64'd1 << 17));
        end else begin
          g = (20 * (FULL_TURN - frac) + (64'd1 << 16)) >> 17;
        end
        w = 2 * longint'(g) - UNIT_LEVEL;
      end
      default: begin
        // Sine, and the spare codes fall back to it.
        w = sine_q15(frac);
      end
    endcase
    u   = w + UNIT_LEVEL;
    d   = longint'(cur_max) - longint'(cur_min);
    lvl = ((u * d + 64'sd32768) >>> 16) + longint'(cur_min);
    if (lvl < 0) begin
      lvl = 0;
    end
    if (lvl > UNIT_LEVEL) begin
      lvl = UNIT_LEVEL;
    end
    return lvl[LEVEL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one phase beat, with random idle cycles in front of it. Valid stays
  // high after the beat so that back-to-back beats need no extra edge.
  task automatic send_phase(input logic [PHASE_W-1:0] phase);
    level_beat_t beat;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      phase_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    phase_bus.valid       <= 1'b1;
    phase_bus.phase_index <= phase;
    do @(posedge clk_i); while (!phase_bus.ready);
    beat.phase = phase;
    beat.level = wave_level(phase);
    pending_levels = {pending_levels, beat};
    phase_beats++;
  endtask

  // Drops valid and waits for every owed level; each phase beat yields one
  // level, so an empty queue means the pipeline is empty too.
  task automatic finish_stream();
    phase_bus.valid <= 1'b0;
    while (pending_levels.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One register write beat; leaves valid high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CFG_WAVE_SHAPE: cur_shape = value[SHAPE_W-1:0];
      CFG_MIN_LEVEL:  cur_min   = value;
      CFG_MAX_LEVEL:  cur_max   = value;
      default:        ;
    endcase
  endtask

  // New setting with the block idle. The shape word carries junk in its upper
  // bits; a write to the index past the list may follow and must change nothing.
  task automatic configure(input logic [CFG_DATA_W-1:0] shape_word,
                           input logic [LEVEL_W-1:0]    lo,
                           input logic [LEVEL_W-1:0]    hi,
                           input bit                    with_spare);
    finish_stream();
    write_reg(CFG_WAVE_SHAPE, shape_word);
    write_reg(CFG_MIN_LEVEL, lo);
    write_reg(CFG_MAX_LEVEL, hi);
    if (with_spare) begin
      write_reg(CFG_SPARE_INDEX, 16'($urandom));
    end
    cfg_bus.valid <= 1'b0;
    settings_count++;
  endtask

  // Level register values biased towards the extremes.
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return LEVEL_W'(ONE_Q15);
      2:       return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Level sink: random back-pressure, checking, activity count
  // ---------------------------------------------------------------------------

  initial begin
    level_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      level_bus.ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_levels
    level_beat_t want;
    if (rst_ni) begin
      if ((phase_bus.valid && phase_bus.ready) || (level_bus.valid && level_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (level_bus.valid && level_bus.ready) begin
        level_beats++;
        if (pending_levels.size() == 0) begin
          $display("%0t: unexpected level beat: expected none, actual %0d",
                   $time, level_bus.level);
          level_errors++;
        end else begin
          want = pending_levels.pop_front();
          if (level_bus.level !== want.level) begin
            $display("%0t: level for phase %0d: expected %0d, actual %0d",
                     $time, want.phase, want.level, level_bus.level);
            level_errors++;
          end
        end
      end
    end
  end

  // Hang detection: nothing moved on any channel for too long.
  initial begin
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk_i);
    end
    $display("%0t: no beat for %0d cycles, %0d levels outstanding",
             $time, HANG_LIMIT, pending_levels.size());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setting: sine between 0 and 1.0, at the quadrant boundaries and the last step.
  task automatic test_reset_state();
    send_phase(PHASE_W'(0));
    send_phase(PHASE_W'(QUARTER));
    send_phase(PHASE_W'(2 * QUARTER));
    send_phase(PHASE_W'(3 * QUARTER));
    send_phase('1);
  endtask

  // Each shape at its edges: square at zero and at one half, triangle mid-rise and trough,
  // the sawtooth knee, cosine peak and trough, and a spare code that falls back to sine.
  task automatic test_each_shape();
    configure(CFG_DATA_W'(SHAPE_SQUARE), '0, LEVEL_W'(ONE_Q15), 1'b0);
    send_phase(PHASE_W'(0));
    send_phase(PHASE_W'(1));
    send_phase(PHASE_W'(2 * QUARTER - 1));
    send_phase(PHASE_W'(2 * QUARTER));
    configure(CFG_DATA_W'(SHAPE_TRIANGLE), '0, LEVEL_W'(ONE_Q15), 1'b0);
    send_phase(PHASE_W'(QUARTER / 2));
    send_phase(PHASE_W'(3 * QUARTER));
    configure(CFG_DATA_W'(SHAPE_COSINE), '0, LEVEL_W'(ONE_Q15), 1'b0);
    send_phase(PHASE_W'(0));
    send_phase(PHASE_W'(2 * QUARTER));
    configure(CFG_DATA_W'(SHAPE_SAWTOOTH), '0, LEVEL_W'(ONE_Q15), 1'b0);
    send_phase(PHASE_W'(SAW_KNEE));
    send_phase(PHASE_W'(SAW_KNEE + 1));
    configure({13'h1fff, SHAPE_SPARE_LAST}, '0, LEVEL_W'(ONE_Q15), 1'b0);
    send_phase(PHASE_W'(QUARTER));
  endtask

  // Level mapping: minimum above maximum inverts, oversized ranges clamp at 1.0.
  task automatic test_level_mapping();
    configure(CFG_DATA_W'(SHAPE_SINE), LEVEL_W'(ONE_Q15), '0, 1'b0);
    send_phase(PHASE_W'(QUARTER));
    send_phase(PHASE_W'(3 * QUARTER));
    configure(CFG_DATA_W'(SHAPE_SINE), '1, '1, 1'b0);
    send_phase(PHASE_W'(0));
    configure(CFG_DATA_W'(SHAPE_SINE), '0, '1, 1'b0);
    send_phase(PHASE_W'(QUARTER));
    send_phase(PHASE_W'(3 * QUARTER));
  endtask

  // A write past the register list must leave the triangle setting in place.
  task automatic test_spare_index();
    configure(CFG_DATA_W'(SHAPE_TRIANGLE), LEVEL_W'(ONE_Q15 / 4), LEVEL_W'(ONE_Q15), 1'b1);
    send_phase(PHASE_W'(2 * QUARTER + QUARTER / 2));
  endtask

  // Random settings, each followed by a run of mostly random phases; one in
  // eight lands on or next to a quadrant boundary.
  task automatic test_random_stream(input int unsigned beats);
    int unsigned        left;
    int unsigned        run;
    logic [SHAPE_W-1:0] shape;
    logic [PHASE_W-1:0] phase;
    left = beats;
    while (left > 0) begin
      shape = SHAPE_W'($urandom_range(0, 7));
      configure({13'($urandom), shape}, pick_level(), pick_level(),
                $urandom_range(0, 3) == 0);
      run = $urandom_range(8, 60);
      if (run > left) begin
        run = left;
      end
      repeat (run) begin
        if ($urandom_range(0, 7) == 0) begin
          phase = PHASE_W'($urandom_range(0, 3) * QUARTER + $urandom_range(0, 2) - 1);
        end else begin
          phase = PHASE_W'($urandom_range(0, 2047));
        end
        send_phase(phase);
      end
      left -= run;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                <= 1'b0;
    phase_bus.valid       <= 1'b0;
    phase_bus.phase_index <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= CFG_WAVE_SHAPE;
    cfg_bus.data          <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender mostly busy, sink stalling most of the time.
    send_idle_pct   = 15;
    ready_stall_pct = 77;
    test_reset_state();
    test_each_shape();
    test_level_mapping();
    test_spare_index();
    test_random_stream(380);

    // Sender sparse, sink nearly always ready.
    send_idle_pct   = 77;
    ready_stall_pct = 15;
    test_random_stream(380);

    // Full rate both ways.
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    test_random_stream(370);

    finish_stream();
    // Three-stage pipeline: spare edges after the drain catch any stray level beat.
    repeat (8) @(posedge clk_i);

    if (pending_levels.size() != 0) begin
      $display("%0t: %0d level beats never arrived", $time, pending_levels.size());
    end
    $display("Covered %0d phase beats and %0d level beats over %0d register settings,",
             phase_beats, level_beats, settings_count);
    $display("all eight shape codes, inverted and clamped ranges, three back-pressure mixes.");
    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pwg_pkg.sv
rtl/core/pwg_intf.sv
rtl/core/pwg_cfg_regs.sv
rtl/core/pwg_qrom.sv
rtl/core/pwg_wave_gen.sv
rtl/core/pwg_level_map.sv
rtl/core/periodic_waveform_level_generator.sv
test/periodic_waveform_level_generator_tb.sv
